/* hdl/hwm_pkg.sv */
// Package for the hue wobble modulator: the item type and the constant
// scaling tables. No dependencies.
`timescale 1ns / 1ps

package hwm_pkg;

    localparam int CC_DEPTH = 128;

    typedef logic [7:0] scale_lut_t    [CC_DEPTH];
    typedef logic [5:0] interval_lut_t [CC_DEPTH];

    // One control update as it travels between the modules.
    typedef struct packed {
        logic [6:0] cc_hue;
        logic [6:0] cc_sat;
        logic [6:0] cc_val;
        logic       mode;
    } hwm_item_t;

    // Truncating map of a 7-bit control onto 0..top.
    function automatic scale_lut_t build_scale(input int top);
        scale_lut_t lut;
        for (int i = 0; i < CC_DEPTH; i++)
        begin
            lut[i] = 8'((i * top) / 127);
        end
        return lut;
    endfunction

    // Tick interval, 1..50, taken from the scaled saturation.
    function automatic interval_lut_t build_interval();
        interval_lut_t lut;
        for (int i = 0; i < CC_DEPTH; i++)
        begin
            lut[i] = 6'((((i * 255) / 127) * 49) / 255 + 1);
        end
        return lut;
    endfunction

    // Half of the wobble range, 2..62, taken from the scaled value.
    function automatic interval_lut_t build_half_range();
        interval_lut_t lut;
        for (int i = 0; i < CC_DEPTH; i++)
        begin
            lut[i] = 6'(((((i * 255) / 127) * 120) / 255 + 5) / 2);
        end
        return lut;
    endfunction

    localparam scale_lut_t    HUE_LUT      = build_scale(250);
    localparam scale_lut_t    LEVEL_LUT    = build_scale(255);
    localparam interval_lut_t INTERVAL_LUT = build_interval();
    localparam interval_lut_t HALF_LUT     = build_half_range();

    localparam logic [7:0] FULL_LEVEL = 8'd255;

endpackage

/* hdl/hwm_if.sv */
// Handshake channels of the hue wobble modulator: the control update channel
// and the colour result channel. No dependencies.
`timescale 1ns / 1ps

interface hwm_upd_if;
    logic       valid;
    logic       ready;
    logic [6:0] cc_hue;
    logic [6:0] cc_sat;
    logic [6:0] cc_val;
    logic       mode;

    modport source (output valid, cc_hue, cc_sat, cc_val, mode, input ready);
    modport sink   (input valid, cc_hue, cc_sat, cc_val, mode, output ready);
endinterface

interface hwm_color_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_hue;
    logic [7:0] out_saturation;
    logic [7:0] out_value;

    modport source (output valid, out_hue, out_saturation, out_value, input ready);
    modport sink   (input valid, out_hue, out_saturation, out_value, output ready);
endinterface

/* hdl/hue_wobble_modulator.sv */
// Hue wobble modulator: an accepted update waits in the input register; its colour item
// is loaded into the result register once that register is empty or being emptied.
// Throughput one item per cycle; the input register and the result register
// form a two-stage pipeline that only stalls when the result is not taken.
// Reset (rst_n low, asynchronous) empties both stages, clears the tick counter
// and hue offset and sets the wobble direction to up.
`timescale 1ns / 1ps

module hue_wobble_modulator (
    input  logic  clk,
    input  logic  rst_n,
    hwm_upd_if.sink     upd,
    hwm_color_if.source color
);
    import hwm_pkg::*;

    // Input stage: the accepted update waits here until the result stage
    // can take it. The offset state advances at the moment it moves on, so
    // every item steps the state exactly once and in order.
    logic      in_valid_reg;
    hwm_item_t in_item_reg;

    // Result stage: holds the finished colour until the sink takes it.
    logic       out_valid_reg;
    logic [7:0] out_hue_reg;
    logic [7:0] out_sat_reg;
    logic [7:0] out_val_reg;

    logic       advance;
    logic [7:0] hue_offset;
    logic [7:0] base_hue;

    // The result stage can load whenever it is empty or being emptied.
    assign advance   = in_valid_reg && (!out_valid_reg || color.ready);
    assign upd.ready = !in_valid_reg || advance;

    hwm_wobble u_wobble (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .item       (in_item_reg),
        .hue_offset (hue_offset)
    );

    assign base_hue = HUE_LUT[in_item_reg.cc_hue];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (upd.ready)
            begin
                in_valid_reg <= upd.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (color.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd.valid && upd.ready)
        begin
            in_item_reg.cc_hue <= upd.cc_hue;
            in_item_reg.cc_sat <= upd.cc_sat;
            in_item_reg.cc_val <= upd.cc_val;
            in_item_reg.mode   <= upd.mode;
        end
        if (advance)
        begin
            // In plain mode the offset reads as zero, so the hue passes as scaled.
            out_hue_reg <= base_hue + hue_offset;
            if (in_item_reg.mode)
            begin
                out_sat_reg <= FULL_LEVEL;
                out_val_reg <= FULL_LEVEL;
            end
            else
            begin
                out_sat_reg <= LEVEL_LUT[in_item_reg.cc_sat];
                out_val_reg <= LEVEL_LUT[in_item_reg.cc_val];
            end
        end
    end

    assign color.valid          = out_valid_reg;
    assign color.out_hue        = out_hue_reg;
    assign color.out_saturation = out_sat_reg;
    assign color.out_value      = out_val_reg;

endmodule

/* hdl/hwm_wobble.sv */
// Hue offset state of the modulator: tick counter, offset and direction.
// Depends on hwm_pkg.
`timescale 1ns / 1ps

module hwm_wobble (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  hwm_pkg::hwm_item_t item,
    output logic [7:0]        hue_offset
);
    import hwm_pkg::*;

    logic [5:0]        tick_count_reg, tick_count_next;
    logic [7:0]        hue_offset_reg, hue_offset_next;
    logic              going_down_reg, going_down_next;

    logic [5:0]        interval;
    logic [5:0]        half;
    logic [5:0]        tick_inc;
    logic              fire;
    logic [7:0]        moved;
    logic signed [9:0] ival, upper, lower;
    logic signed [9:0] off_a, off_b, off_c;
    logic              dir_b, dir_c;
    logic signed [9:0] probe_a, probe_b;

    always_comb
    begin
        interval = INTERVAL_LUT[item.cc_sat];
        half     = HALF_LUT[item.cc_val];
        ival     = $signed({4'b0, interval});
        upper    = $signed({4'b0, half});
        lower    = -upper - 10'sd1;

        tick_inc = tick_count_reg + 6'd1;
        fire     = tick_inc > interval;
        if (fire)
        begin
            moved = going_down_reg ? hue_offset_reg - 8'd1 : hue_offset_reg + 8'd1;
        end
        else
        begin
            moved = hue_offset_reg;
        end

        // Look-ahead against the lower bound, then against the upper bound
        // with the offset and direction that the first check leaves.
        off_a   = $signed({{2{moved[7]}}, moved});
        probe_a = going_down_reg ? off_a + ival : off_a - ival;
        if (probe_a < lower - 10'sd1)
        begin
            off_b = lower;
            dir_b = !going_down_reg;
        end
        else
        begin
            off_b = off_a;
            dir_b = going_down_reg;
        end

        probe_b = dir_b ? off_b - ival : off_b + ival;
        if (probe_b > upper)
        begin
            off_c = upper;
            dir_c = !dir_b;
        end
        else
        begin
            off_c = off_b;
            dir_c = dir_b;
        end

        if (item.mode)
        begin
            tick_count_next = fire ? 6'd0 : tick_inc;
            hue_offset_next = off_c[7:0];
            going_down_next = dir_c;
        end
        else
        begin
            tick_count_next = tick_count_reg;
            hue_offset_next = 8'd0;
            going_down_next = going_down_reg;
        end

        hue_offset = hue_offset_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= 6'd0;
            hue_offset_reg <= 8'd0;
            going_down_reg <= 1'b0;
        end
        else if (step)
        begin
            tick_count_reg <= tick_count_next;
            hue_offset_reg <= hue_offset_next;
            going_down_reg <= going_down_next;
        end
    end

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for hue_wobble_modulator: directed table, then random bursts
// under four handshake phases. Depends on hwm_pkg (hdl/hwm_pkg.sv) and the channel
// interfaces in hdl/hwm_if.sv.
`timescale 1ns / 1ps

module tb_top;

    import hwm_pkg::*;

    // Mode bit codes of the update item.
    localparam bit MODE_PLAIN  = 1'b0;
    localparam bit MODE_WOBBLE = 1'b1;

    // Four handshake phases: no idling, sender idle, receiver stalling, both lightly.
    localparam int PHASES          = 4;
    localparam int IDLE_PCT [4]    = '{0, 76, 0, 10};
    localparam int STALL_PCT [4]   = '{0, 0, 76, 10};
    localparam int ITEMS_PER_PHASE = 320;

    // Length of the single long back-pressure stretch on the colour channel.
    localparam int HOLD_CYCLES = 80;

    // Offset that a downward sweep must pass before the range is collapsed, so that
    // the following item trips the lower and the upper clamp in the same step.
    localparam int SWEEP_FLOOR = -56;

    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] level;
    } colour_t;

    // One row of the directed table. Where typed is set, colour is the result that
    // is expected on the output; otherwise the predictor supplies it.
    typedef struct {
        hwm_item_t upd;
        bit        typed;
        colour_t   colour;
    } drill_row_t;

    localparam int DRILL_ROWS = 21;

    logic clk;
    logic rst_n;

    hwm_upd_if   upd ();
    hwm_color_if color ();

    hue_wobble_modulator u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (upd),
        .color (color)
    );

    // Predictor state, mirroring the block's tick counter, hue offset and direction.
    logic [5:0] wobble_ticks;
    logic [7:0] wobble_offset;
    logic       wobble_down;

    colour_t     expected_colours [$];
    int unsigned error_count;
    int unsigned updates_sent;
    int unsigned wobble_updates;
    int unsigned double_clamps;
    int unsigned colours_checked;

    // Handshake pressure, set by the stimulus process and read by the receiver.
    int unsigned send_idle_pct;
    int unsigned stall_pct;
    int unsigned hold_requests;

    // The directed table. Plain-mode rows do not depend on any state, so their
    // colours are the scaled controls themselves. The first wobble row follows
    // nothing but plain items after reset, so the tick counter and offset are still
    // zero: the hue passes straight through at full saturation and value. Rows in
    // between walk the offset up to its upper clamp with the shortest interval, and
    // a zero hue with a negative offset wraps round the colour circle.
    drill_row_t drill [DRILL_ROWS] = '{
        '{'{7'd0,   7'd0,   7'd0,   MODE_PLAIN},  1'b1, '{8'd0,   8'd0,   8'd0}},
        '{'{7'd127, 7'd127, 7'd127, MODE_PLAIN},  1'b1, '{8'd250, 8'd255, 8'd255}},
        '{'{7'd1,   7'd1,   7'd1,   MODE_PLAIN},  1'b1, '{8'd1,   8'd2,   8'd2}},
        '{'{7'd126, 7'd126, 7'd126, MODE_PLAIN},  1'b1, '{8'd248, 8'd252, 8'd252}},
        '{'{7'd64,  7'd63,  7'd127, MODE_PLAIN},  1'b1, '{8'd125, 8'd126, 8'd255}},
        '{'{7'd85,  7'd42,  7'd106, MODE_PLAIN},  1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{7'd42,  7'd85,  7'd21,  MODE_PLAIN},  1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{7'd0,   7'd0,   7'd0,   MODE_WOBBLE}, 1'b1, '{8'd0,   8'd255, 8'd255}},
        '{'{7'd0,   7'd0,   7'd0,   MODE_WOBBLE}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{7'd0,   7'd0,   7'd0,   MODE_WOBBLE}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{7'd0,   7'd0,   7'd0,   MODE_WOBBLE}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{7'd0,   7'd0,   7'd0,   MODE_WOBBLE}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{7'd0,   7'd0,   7'd0,   MODE_WOBBLE}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{7'd127, 7'd127, 7'd127, MODE_WOBBLE}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{7'd0,   7'd127, 7'd0,   MODE_WOBBLE}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{7'd0,   7'd127, 7'd0,   MODE_WOBBLE}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{7'd127, 7'd0,   7'd127, MODE_WOBBLE}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{7'd127, 7'd0,   7'd0,   MODE_PLAIN},  1'b1, '{8'd250, 8'd0,   8'd0}},
        '{'{7'd127, 7'd64,  7'd64,  MODE_WOBBLE}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{7'd1,   7'd127, 7'd127, MODE_WOBBLE}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{7'd0,   7'd0,   7'd0,   MODE_WOBBLE}, 1'b0, '{8'd0,   8'd0,   8'd0}}
    };

    // The clock runs from time zero with a 4 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 0;
    end

    // Works out the colour that one accepted update produces and advances the
    // predictor state. Plain mode only clears the offset; the tick counter and the
    // direction carry over into the next wobble stretch.
    function automatic colour_t predict_colour(input hwm_item_t u);
        int      hue_lvl;
        int      sat_lvl;
        int      val_lvl;
        int      interval;
        int      half;
        int      lower;
        int      upper;
        int      dir;
        int      off;
        bit      low_hit;
        colour_t c;

        hue_lvl = int'(u.cc_hue) * 250 / 127;
        sat_lvl = int'(u.cc_sat) * 255 / 127;
        val_lvl = int'(u.cc_val) * 255 / 127;

        if (u.mode == MODE_WOBBLE)
        begin
            wobble_updates++;
            interval = sat_lvl * 49 / 255 + 1;
            half     = (val_lvl * 120 / 255 + 5) / 2;
            lower    = -half - 1;
            upper    = half;

            // The counter steps first; once it passes the interval the offset
            // moves by one in the current direction, wrapping within 8 bits.
            wobble_ticks = wobble_ticks + 6'd1;
            if (int'(wobble_ticks) > interval)
            begin
                wobble_offset = wobble_down ? wobble_offset - 8'd1 : wobble_offset + 8'd1;
                wobble_ticks  = '0;
            end

            // Look-ahead clamps: the lower one first, then the upper one with the
            // possibly reversed direction. Both may fire in the same step.
            off     = int'($signed(wobble_offset));
            dir     = wobble_down ? -1 : 1;
            low_hit = 1'b0;
            if (off - dir * interval < lower - 1)
            begin
                off         = lower;
                wobble_down = !wobble_down;
                dir         = -dir;
                low_hit     = 1'b1;
            end
            if (off + dir * interval > upper)
            begin
                off         = upper;
                wobble_down = !wobble_down;
                if (low_hit)
                begin
                    double_clamps++;
                end
            end
            wobble_offset = 8'(off);

            c.hue   = 8'(hue_lvl) + wobble_offset;
            c.sat   = 8'hFF;
            c.level = 8'hFF;
        end
        else
        begin
            wobble_offset = '0;
            c.hue   = 8'(hue_lvl);
            c.sat   = 8'(sat_lvl);
            c.level = 8'(val_lvl);
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < MAX_PRINTED)
        begin
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        end
        error_count++;
    endtask

    // Compares the colour item on the output with the oldest expectation.
    task automatic check_colour();
        colour_t want;
        if (expected_colours.size() == 0)
        begin
            report_mismatch("unexpected colour item, queue depth", 1, 0);
        end
        else
        begin
            want = expected_colours.pop_front();
            if (color.out_hue !== want.hue)
            begin
                report_mismatch("out_hue", int'(color.out_hue), int'(want.hue));
            end
            if (color.out_saturation !== want.sat)
            begin
                report_mismatch("out_saturation", int'(color.out_saturation), int'(want.sat));
            end
            if (color.out_value !== want.level)
            begin
                report_mismatch("out_value", int'(color.out_value), int'(want.level));
            end
            colours_checked++;
        end
    endtask

    // Offers one update, idling beforehand as the current phase asks, and waits for
    // the block to take it. The expectation is queued at acceptance.
    task automatic send_update(input hwm_item_t u, input bit use_typed = 1'b0,
                               input colour_t typed = '0);
        colour_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            upd.valid <= 1'b0;
            @(posedge clk);
        end
        upd.valid  <= 1'b1;
        upd.cc_hue <= u.cc_hue;
        upd.cc_sat <= u.cc_sat;
        upd.cc_val <= u.cc_val;
        upd.mode   <= u.mode;
        @(posedge clk);
        while (!upd.ready)
        begin
            @(posedge clk);
        end
        predicted = predict_colour(u);
        expected_colours.push_back(use_typed ? typed : predicted);
        updates_sent++;
    endtask

    // Sends one burst of updates. Most bursts are wobble runs with fixed saturation
    // and value and a moving hue, so the offset gets time to travel and bounce; some
    // of those are broken by a stray item. The rest is short random noise. A sweep
    // drives the offset down past the lower bounds of a small range and then
    // collapses the range, so that both clamps fire together.
    task automatic send_burst(input bit sweep);
        hwm_item_t u;
        hwm_item_t stray;
        int        len;
        int        kink;

        u.mode = MODE_WOBBLE;
        if (sweep)
        begin
            u.cc_sat = 7'($urandom_range(0, 2));
            u.cc_val = 7'($urandom_range(120, 127));
            for (int n = 0; n < 600; n++)
            begin
                if (wobble_down && int'($signed(wobble_offset)) < SWEEP_FLOOR)
                begin
                    break;
                end
                u.cc_hue = 7'($urandom_range(0, 127));
                send_update(u);
            end
            u.cc_hue = 7'($urandom_range(0, 127));
            u.cc_sat = 7'd127;
            u.cc_val = 7'($urandom_range(0, 3));
            send_update(u);
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            len = $urandom_range(1, 6);
            for (int n = 0; n < len; n++)
            begin
                u = hwm_item_t'($urandom);
                send_update(u);
            end
        end
        else
        begin
            len  = $urandom_range(8, 60);
            kink = $urandom_range(0, 2 * len);
            u.cc_sat = ($urandom_range(0, 1) == 1) ? 7'($urandom_range(0, 12))
                                                   : 7'($urandom_range(0, 127));
            u.cc_val = 7'($urandom_range(0, 127));
            for (int n = 0; n < len; n++)
            begin
                u.cc_hue = 7'($urandom_range(0, 127));
                if (n == kink)
                begin
                    stray = hwm_item_t'($urandom);
                    send_update(stray);
                end
                else
                begin
                    send_update(u);
                end
            end
        end
    endtask

    // Receiver: checks each colour item taken at a rising edge, then decides the
    // ready for the next cycle. A hold request from the stimulus side keeps ready low
    // for a long stretch, counted here, so the pipeline fills and stalls its input.
    initial
    begin
        int unsigned holds_served;
        int unsigned hold_left;
        holds_served = 0;
        hold_left    = 0;
        color.ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (color.valid && color.ready)
            begin
                check_colour();
            end
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                color.ready <= 1'b0;
            end
            else
            begin
                color.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int unsigned phase_start;

        rst_n           = 1'b0;
        upd.valid       = 1'b0;
        upd.cc_hue      = '0;
        upd.cc_sat      = '0;
        upd.cc_val      = '0;
        upd.mode        = MODE_PLAIN;
        wobble_ticks    = '0;
        wobble_offset   = '0;
        wobble_down     = 1'b0;
        error_count     = 0;
        updates_sent    = 0;
        wobble_updates  = 0;
        double_clamps   = 0;
        colours_checked = 0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        hold_requests   = 0;

        repeat (3)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, with no idling on either side.
        for (int r = 0; r < DRILL_ROWS; r++)
        begin
            send_update(drill[r].upd, drill[r].typed, drill[r].colour);
        end

        // Random bursts, one handshake phase after another. Between phases the
        // sender pauses until every expected colour item has come out.
        for (int p = 0; p < PHASES; p++)
        begin
            send_idle_pct = IDLE_PCT[p];
            stall_pct     = STALL_PCT[p];
            phase_start   = updates_sent;
            while (updates_sent - phase_start < ITEMS_PER_PHASE)
            begin
                send_burst(p == 0 && updates_sent == phase_start);
                // Halfway through the unthrottled phase, hold the output back
                // while the sender keeps offering.
                if (p == 0 && hold_requests == 0 &&
                    updates_sent - phase_start >= ITEMS_PER_PHASE / 2)
                begin
                    hold_requests++;
                end
            end
            upd.valid <= 1'b0;
            @(posedge clk);
            while (expected_colours.size() != 0)
            begin
                @(posedge clk);
            end
        end

        // Allow for the two-stage latency and then some, so that any surplus
        // colour item is caught by the receiver.
        repeat (10)
        begin
            @(posedge clk);
        end

        $display("Run covered %0d updates (%0d in wobble mode), %0d colour items checked,",
                 updates_sent, wobble_updates, colours_checked);
        $display("four handshake phases and a long output hold; both clamps fired %0d times.",
                 double_clamps);
        if (error_count == 0)
        begin
            $display("hue_wobble_modulator regression: pass");
        end
        else
        begin
            $display("hue_wobble_modulator regression: fail");
        end
        $finish;
    end

    // Watchdog: the slowest correct run needs a few tens of microseconds.
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d colour items still expected.", expected_colours.size());
        $display("hue_wobble_modulator regression: fail");
        $finish;
    end

endmodule
